### hdl/lqtp_pkg.sv
// lqtp_pkg: shared types, constants and helpers for the linked queue and tree pool manager
// used by lqtp_link_mem, lqtp_seq and the top level; depends on nothing
package lqtp_pkg;

  localparam int POOL_SIZE = 32;
  localparam int IDX_W     = $clog2(POOL_SIZE);
  localparam int LINK_W    = IDX_W + 1;
  localparam int STEP_W    = $clog2(POOL_SIZE + 1);
  localparam int NUM_FLD   = 6;

  // field slots of one link record
  localparam int F_NEXT   = 0;
  localparam int F_PREV   = 1;
  localparam int F_PARENT = 2;
  localparam int F_FCHILD = 3;
  localparam int F_NSIB   = 4;
  localparam int F_PSIB   = 5;

  typedef logic [LINK_W-1:0] link_t;
  typedef link_t [NUM_FLD-1:0] link_rec_t;

  localparam link_t NONE_LINK = LINK_W'(POOL_SIZE);

  typedef enum logic [3:0] {
    FN_ALLOC    = 4'd0,
    FN_FREE     = 4'd1,
    FN_ENQ      = 4'd2,
    FN_DEQ      = 4'd3,
    FN_REMOVE   = 4'd4,
    FN_PEEK     = 4'd5,
    FN_ADD      = 4'd6,
    FN_DETACH   = 4'd7,
    FN_DETACH_1 = 4'd8,
    FN_HAS      = 4'd9
  } func_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_Q_RD,
    ST_UNLINK,
    ST_UN_W2,
    ST_SEARCH,
    ST_CLR,
    ST_FR_CLR,
    ST_AP_START,
    ST_AP_RD,
    ST_AP_W2,
    ST_AP_W3,
    ST_AP_W4,
    ST_ADD_RD,
    ST_ADD_W2,
    ST_ADD_W3,
    ST_HAS_RD,
    ST_FC_RD,
    ST_DT_RD,
    ST_DT_W1,
    ST_DT_W2,
    ST_DT_W3,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [3:0] func;
    logic [5:0] queue_tail;
    logic [4:0] entry_index;
    logic [4:0] parent_index;
  } in_item_t;

  typedef struct packed {
    logic [5:0] new_tail;
    logic [5:0] result_entry;
    logic       has_children;
  } out_item_t;

  typedef struct packed {
    logic                 re;
    link_t                raddr;
    link_t                waddr;
    logic [NUM_FLD-1:0]   wmask;
    link_rec_t            wdata;
  } mem_req_t;

  // value an entry's field holds before it is first written
  function automatic link_t rst_link(input int fld, input logic [IDX_W-1:0] idx);
    link_t v;
    v = NONE_LINK;
    if (fld == F_NEXT) begin
      v = (idx == IDX_W'(POOL_SIZE - 1)) ? '0 : LINK_W'(idx) + LINK_W'(1);
    end else if (fld == F_PREV) begin
      v = (idx == '0) ? LINK_W'(POOL_SIZE - 1) : LINK_W'(idx) - LINK_W'(1);
    end
    return v;
  endfunction

endpackage

### hdl/lqtp_link_mem.sv
// lqtp_link_mem: link store, six link fields per entry, per-field write enables
// one read port with registered data, per-field valid bits give the reset image; uses lqtp_pkg
module lqtp_link_mem (
  input  logic                clk,
  input  logic                rst_n,
  input  lqtp_pkg::mem_req_t  req,
  output lqtp_pkg::link_rec_t rdata
);
  import lqtp_pkg::*;

  logic [LINK_W-1:0]    mem_r [NUM_FLD][POOL_SIZE];
  logic [POOL_SIZE-1:0] vld_r [NUM_FLD];

  logic              wr_ok;
  logic              rd_ok;
  logic [IDX_W-1:0]  widx;
  logic [IDX_W-1:0]  ridx;

  link_rec_t          dat_r;
  logic [NUM_FLD-1:0] vq_r;
  logic               ok_r;
  logic [IDX_W-1:0]   ridx_r;

  assign wr_ok = req.waddr < NONE_LINK;
  assign rd_ok = req.raddr < NONE_LINK;
  assign widx  = req.waddr[IDX_W-1:0];
  assign ridx  = req.raddr[IDX_W-1:0];

  always_ff @(posedge clk) begin
    for (int f = 0; f < NUM_FLD; f++) begin
      if (wr_ok && req.wmask[f]) begin
        mem_r[f][widx] <= req.wdata[f];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int f = 0; f < NUM_FLD; f++) begin
        vld_r[f] <= '0;
      end
    end else begin
      for (int f = 0; f < NUM_FLD; f++) begin
        if (wr_ok && req.wmask[f]) begin
          vld_r[f][widx] <= 1'b1;
        end
      end
    end
  end

  // read with write-through forwarding on the same entry
  always_ff @(posedge clk) begin
    if (req.re) begin
      ok_r   <= rd_ok;
      ridx_r <= ridx;
      for (int f = 0; f < NUM_FLD; f++) begin
        if (wr_ok && req.wmask[f] && (req.waddr == req.raddr)) begin
          dat_r[f] <= req.wdata[f];
          vq_r[f]  <= 1'b1;
        end else begin
          dat_r[f] <= mem_r[f][ridx];
          vq_r[f]  <= vld_r[f][ridx];
        end
      end
    end
  end

  always_comb begin
    for (int f = 0; f < NUM_FLD; f++) begin
      if (!ok_r) begin
        rdata[f] = NONE_LINK;
      end else if (vq_r[f]) begin
        rdata[f] = dat_r[f];
      end else begin
        rdata[f] = rst_link(f, ridx_r);
      end
    end
  end

endmodule

### hdl/lqtp_seq.sv
// lqtp_seq: operation sequencer, one read or one write to the link store per cycle
// holds the free-list tail and the item in flight; uses lqtp_pkg
module lqtp_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lqtp_pkg::in_item_t  in_item,
  output logic                out_valid,
  output lqtp_pkg::out_item_t out_item,
  output lqtp_pkg::mem_req_t  mem_req,
  input  lqtp_pkg::link_rec_t mem_rdata
);
  import lqtp_pkg::*;

  state_t             state_r, state_nxt;
  func_t              func_r, func_nxt;
  link_t              tail_r, tail_nxt;
  link_t              e_r, e_nxt;
  link_t              par_r, par_nxt;
  link_t              wt_r, wt_nxt;
  link_t              ftail_r, ftail_nxt;
  link_t              res_r, res_nxt;
  logic               kids_r, kids_nxt;
  link_t              n_r, n_nxt;
  link_t              q_r, q_nxt;
  link_t              prn_r, prn_nxt;
  link_t              sn_r, sn_nxt;
  link_t              sp_r, sp_nxt;
  logic [STEP_W-1:0]  steps_r, steps_nxt;
  logic               tupd_r, tupd_nxt;

  func_t in_func;
  link_t tn;
  link_t h;
  link_t fc;
  logic  ftail_op;
  logic  srch_stop;

  assign in_func   = func_t'(in_item.func);
  assign tn        = (in_item.queue_tail >= NONE_LINK) ? NONE_LINK : in_item.queue_tail;
  assign h         = mem_rdata[F_NEXT];
  assign fc        = mem_rdata[F_FCHILD];
  assign ftail_op  = (func_r == FN_ALLOC) || (func_r == FN_FREE);
  assign srch_stop = (steps_r == STEP_W'(POOL_SIZE)) || (h == wt_r) || (h == NONE_LINK);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_func)
            FN_ALLOC, FN_DEQ, FN_REMOVE, FN_PEEK: state_nxt = ST_Q_RD;
            FN_FREE:                              state_nxt = ST_FR_CLR;
            FN_ENQ:                               state_nxt = ST_AP_START;
            FN_ADD:                               state_nxt = ST_ADD_RD;
            FN_HAS:                               state_nxt = ST_HAS_RD;
            FN_DETACH:                            state_nxt = ST_DT_RD;
            FN_DETACH_1:                          state_nxt = ST_FC_RD;
            default:                              state_nxt = ST_FIN;
          endcase
        end
      end
      ST_Q_RD: begin
        unique case (func_r)
          FN_ALLOC, FN_DEQ: begin
            if (h == wt_r) begin
              state_nxt = (func_r == FN_ALLOC) ? ST_CLR : ST_FIN;
            end else if (h == NONE_LINK) begin
              state_nxt = ST_FIN;
            end else begin
              state_nxt = ST_UNLINK;
            end
          end
          FN_REMOVE: begin
            if (e_r == wt_r) begin
              state_nxt = (h == wt_r) ? ST_FIN : ST_UNLINK;
            end else begin
              state_nxt = ST_SEARCH;
            end
          end
          default: state_nxt = ST_FIN;
        endcase
      end
      ST_UNLINK:   state_nxt = ST_UN_W2;
      ST_UN_W2:    state_nxt = (func_r == FN_ALLOC) ? ST_CLR : ST_FIN;
      ST_SEARCH: begin
        priority if (srch_stop) begin
          state_nxt = ST_FIN;
        end else if (h == e_r) begin
          state_nxt = ST_UNLINK;
        end else begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_CLR:      state_nxt = ST_FIN;
      ST_FR_CLR:   state_nxt = ST_AP_START;
      ST_AP_START: state_nxt = (wt_r == NONE_LINK) ? ST_FIN : ST_AP_RD;
      ST_AP_RD:    state_nxt = ST_AP_W2;
      ST_AP_W2:    state_nxt = ST_AP_W3;
      ST_AP_W3:    state_nxt = ST_AP_W4;
      ST_AP_W4:    state_nxt = ST_FIN;
      ST_ADD_RD:   state_nxt = ST_ADD_W2;
      ST_ADD_W2:   state_nxt = ST_ADD_W3;
      ST_ADD_W3:   state_nxt = ST_FIN;
      ST_HAS_RD:   state_nxt = ST_FIN;
      ST_FC_RD:    state_nxt = (fc == NONE_LINK) ? ST_FIN : ST_DT_RD;
      ST_DT_RD:    state_nxt = (mem_rdata[F_PARENT] == NONE_LINK) ? ST_FIN : ST_DT_W1;
      ST_DT_W1:    state_nxt = (sn_r == NONE_LINK) ? ST_DT_W3 : ST_DT_W2;
      ST_DT_W2:    state_nxt = ST_DT_W3;
      ST_DT_W3:    state_nxt = ST_FIN;
      ST_FIN:      state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // store accesses and working registers
  always_comb begin
    func_nxt  = func_r;
    tail_nxt  = tail_r;
    e_nxt     = e_r;
    par_nxt   = par_r;
    wt_nxt    = wt_r;
    ftail_nxt = ftail_r;
    res_nxt   = res_r;
    kids_nxt  = kids_r;
    n_nxt     = n_r;
    q_nxt     = q_r;
    prn_nxt   = prn_r;
    sn_nxt    = sn_r;
    sp_nxt    = sp_r;
    steps_nxt = steps_r;
    tupd_nxt  = tupd_r;
    mem_req   = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          func_nxt  = in_func;
          tail_nxt  = tn;
          e_nxt     = {1'b0, in_item.entry_index};
          par_nxt   = {1'b0, in_item.parent_index};
          res_nxt   = NONE_LINK;
          kids_nxt  = 1'b0;
          steps_nxt = '0;
          tupd_nxt  = 1'b0;
          wt_nxt    = (in_func == FN_ALLOC || in_func == FN_FREE) ? ftail_r : tn;
          unique case (in_func)
            FN_ALLOC: begin
              mem_req.re    = 1'b1;
              mem_req.raddr = ftail_r;
            end
            FN_DEQ, FN_REMOVE, FN_PEEK: begin
              mem_req.re    = 1'b1;
              mem_req.raddr = tn;
            end
            FN_ADD, FN_HAS, FN_DETACH_1: begin
              mem_req.re    = 1'b1;
              mem_req.raddr = {1'b0, in_item.parent_index};
            end
            FN_DETACH: begin
              mem_req.re    = 1'b1;
              mem_req.raddr = {1'b0, in_item.entry_index};
            end
            default: ;
          endcase
        end
      end
      ST_Q_RD: begin
        unique case (func_r)
          FN_PEEK: res_nxt = h;
          FN_ALLOC, FN_DEQ: begin
            if (h == wt_r) begin
              res_nxt = wt_r;
              wt_nxt  = NONE_LINK;
            end else if (h != NONE_LINK) begin
              res_nxt       = h;
              mem_req.re    = 1'b1;
              mem_req.raddr = h;
            end
          end
          FN_REMOVE: begin
            if (e_r == wt_r) begin
              res_nxt = wt_r;
              if (h == wt_r) begin
                wt_nxt = NONE_LINK;
              end else begin
                tupd_nxt = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      ST_UNLINK: begin
        // prev of successor takes our predecessor
        n_nxt                   = mem_rdata[F_NEXT];
        q_nxt                   = mem_rdata[F_PREV];
        mem_req.waddr           = mem_rdata[F_NEXT];
        mem_req.wmask[F_PREV]   = 1'b1;
        mem_req.wdata[F_PREV]   = mem_rdata[F_PREV];
      end
      ST_UN_W2: begin
        mem_req.waddr         = q_r;
        mem_req.wmask[F_NEXT] = 1'b1;
        mem_req.wdata[F_NEXT] = n_r;
        if (tupd_r) begin
          wt_nxt = q_r;
        end
      end
      ST_SEARCH: begin
        // walk one link per cycle
        if (!srch_stop) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = h;
          if (h == e_r) begin
            res_nxt = h;
          end else begin
            steps_nxt = steps_r + STEP_W'(1);
          end
        end
      end
      ST_CLR: begin
        mem_req.waddr = res_r;
        mem_req.wmask = '1;
        mem_req.wdata = {NUM_FLD{NONE_LINK}};
      end
      ST_FR_CLR: begin
        mem_req.waddr = e_r;
        mem_req.wmask = '1;
        mem_req.wdata = {NUM_FLD{NONE_LINK}};
      end
      ST_AP_START: begin
        if (wt_r == NONE_LINK) begin
          mem_req.waddr         = e_r;
          mem_req.wmask[F_NEXT] = 1'b1;
          mem_req.wmask[F_PREV] = 1'b1;
          mem_req.wdata[F_NEXT] = e_r;
          mem_req.wdata[F_PREV] = e_r;
          wt_nxt                = e_r;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = wt_r;
        end
      end
      ST_AP_RD: begin
        n_nxt                 = h;
        mem_req.waddr         = h;
        mem_req.wmask[F_PREV] = 1'b1;
        mem_req.wdata[F_PREV] = e_r;
      end
      ST_AP_W2: begin
        mem_req.waddr         = e_r;
        mem_req.wmask[F_NEXT] = 1'b1;
        mem_req.wdata[F_NEXT] = n_r;
      end
      ST_AP_W3: begin
        mem_req.waddr         = wt_r;
        mem_req.wmask[F_NEXT] = 1'b1;
        mem_req.wdata[F_NEXT] = e_r;
      end
      ST_AP_W4: begin
        mem_req.waddr         = e_r;
        mem_req.wmask[F_PREV] = 1'b1;
        mem_req.wdata[F_PREV] = wt_r;
        wt_nxt                = e_r;
      end
      ST_ADD_RD: begin
        n_nxt                 = fc;
        mem_req.waddr         = fc;
        mem_req.wmask[F_PSIB] = 1'b1;
        mem_req.wdata[F_PSIB] = e_r;
      end
      ST_ADD_W2: begin
        mem_req.waddr           = e_r;
        mem_req.wmask[F_NSIB]   = 1'b1;
        mem_req.wmask[F_PSIB]   = 1'b1;
        mem_req.wmask[F_PARENT] = 1'b1;
        mem_req.wdata[F_NSIB]   = n_r;
        mem_req.wdata[F_PSIB]   = NONE_LINK;
        mem_req.wdata[F_PARENT] = par_r;
      end
      ST_ADD_W3: begin
        mem_req.waddr           = par_r;
        mem_req.wmask[F_FCHILD] = 1'b1;
        mem_req.wdata[F_FCHILD] = e_r;
      end
      ST_HAS_RD: kids_nxt = (fc != NONE_LINK);
      ST_FC_RD: begin
        if (fc != NONE_LINK) begin
          e_nxt         = fc;
          mem_req.re    = 1'b1;
          mem_req.raddr = fc;
        end
      end
      ST_DT_RD: begin
        prn_nxt = mem_rdata[F_PARENT];
        sn_nxt  = mem_rdata[F_NSIB];
        sp_nxt  = mem_rdata[F_PSIB];
        if (mem_rdata[F_PARENT] != NONE_LINK) begin
          res_nxt = e_r;
        end
      end
      ST_DT_W1: begin
        priority if (sn_r == NONE_LINK && sp_r == NONE_LINK) begin
          // only child
          mem_req.waddr           = prn_r;
          mem_req.wmask[F_FCHILD] = 1'b1;
          mem_req.wdata[F_FCHILD] = NONE_LINK;
        end else if (sn_r == NONE_LINK) begin
          // last child
          mem_req.waddr         = sp_r;
          mem_req.wmask[F_NSIB] = 1'b1;
          mem_req.wdata[F_NSIB] = NONE_LINK;
        end else if (sp_r == NONE_LINK) begin
          // first child, successor moves up
          mem_req.waddr           = prn_r;
          mem_req.wmask[F_FCHILD] = 1'b1;
          mem_req.wdata[F_FCHILD] = sn_r;
        end else begin
          mem_req.waddr         = sn_r;
          mem_req.wmask[F_PSIB] = 1'b1;
          mem_req.wdata[F_PSIB] = sp_r;
        end
      end
      ST_DT_W2: begin
        if (sp_r == NONE_LINK) begin
          mem_req.waddr         = sn_r;
          mem_req.wmask[F_PSIB] = 1'b1;
          mem_req.wdata[F_PSIB] = NONE_LINK;
        end else begin
          mem_req.waddr         = sp_r;
          mem_req.wmask[F_NSIB] = 1'b1;
          mem_req.wdata[F_NSIB] = sn_r;
        end
      end
      ST_DT_W3: begin
        mem_req.waddr           = e_r;
        mem_req.wmask[F_PARENT] = 1'b1;
        mem_req.wdata[F_PARENT] = NONE_LINK;
      end
      ST_FIN: begin
        if (ftail_op) begin
          ftail_nxt = wt_r;
        end
      end
      default: ;
    endcase
  end

  // result port
  always_comb begin
    busy                  = (state_r != ST_IDLE);
    out_valid             = (state_r == ST_FIN);
    out_item.new_tail     = ftail_op ? tail_r : wt_r;
    out_item.result_entry = res_r;
    out_item.has_children = kids_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ftail_r <= LINK_W'(POOL_SIZE - 1);
    end else begin
      state_r <= state_nxt;
      ftail_r <= ftail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    tail_r  <= tail_nxt;
    e_r     <= e_nxt;
    par_r   <= par_nxt;
    wt_r    <= wt_nxt;
    res_r   <= res_nxt;
    kids_r  <= kids_nxt;
    n_r     <= n_nxt;
    q_r     <= q_nxt;
    prn_r   <= prn_nxt;
    sn_r    <= sn_nxt;
    sp_r    <= sp_nxt;
    steps_r <= steps_nxt;
    tupd_r  <= tupd_nxt;
  end

  a_fin_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN |=> state_r == ST_IDLE)
    else $error("result strobe longer than one cycle");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> mem_req.wmask == '0)
    else $error("link store written while idle");

  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEARCH |-> steps_r <= STEP_W'(POOL_SIZE))
    else $error("search ran past the pool size");

  a_ftail_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_FIN |=> $stable(ftail_r))
    else $error("free tail changed outside completion");

endmodule

### hdl/linked_queue_and_tree_pool_manager.sv
// linked_queue_and_tree_pool_manager: top level of the pool manager
// instantiates lqtp_seq and lqtp_link_mem; uses lqtp_pkg
//
// usage
// - a fixed pool of 32 entries is linked into circular doubly linked queues
//   (named by tail index), a free list, and parent/child/sibling trees
// - input channel: drive in_item and raise start; the item is taken at the
//   rising edge where start is high and busy is low
// - result channel: out_valid strobes for exactly one cycle with out_item;
//   the receiver cannot stall, so the result must be captured that cycle
// - every item gives one result; busy is high from acceptance through the
//   strobe cycle and low in the cycle after it
// - unused function codes go straight to the strobe; remove entry walks the
//   queue one link per cycle out of the link store's single read port, up to
//   32 links
// - one item at a time: the next item is taken the cycle after the strobe
// - reset (synchronous, active low) puts every entry in the free list in
//   index order and all tree links to none; the store's per-field valid
//   bits give that image at once, no clearing pass
module linked_queue_and_tree_pool_manager (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lqtp_pkg::in_item_t  in_item,
  output logic                out_valid,
  output lqtp_pkg::out_item_t out_item
);
  import lqtp_pkg::*;

  // sequencer to link store
  mem_req_t  mem_req;
  link_rec_t mem_rdata;

  // operation sequencer: one store access per cycle
  lqtp_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  // link store: six link fields per entry, registered read data
  lqtp_link_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule
